// ===== src/htd_pkg.sv =====
// shared types, constants and helpers of the huffman tree decoder
// no dependencies; used by htd_front, htd_back and huffman_tree_decoder
package htd_pkg;

	localparam int NODE_COUNT = 1024;
	localparam int ADDR_W     = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;

	localparam int IDX_W    = 10;
	localparam int SYM_W    = 9;
	localparam int BYTE_W   = 8;
	localparam int OP_W     = 2;
	localparam int STATUS_W = 3;
	localparam int ENTRY_W  = 1 + SYM_W + 2 * IDX_W;

	localparam int CFG_W     = 10;
	localparam int CFG_IDX_W = 1;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// op codes of a request
	localparam logic [OP_W-1:0] OP_WRITE   = 2'd0;
	localparam logic [OP_W-1:0] OP_DECODE  = 2'd1;
	localparam logic [OP_W-1:0] OP_RESTART = 2'd2;

	// result status codes
	localparam logic [STATUS_W-1:0] ST_NONE    = 3'd0;
	localparam logic [STATUS_W-1:0] ST_SYMBOL  = 3'd1;
	localparam logic [STATUS_W-1:0] ST_END     = 3'd2;
	localparam logic [STATUS_W-1:0] ST_EMPTY   = 3'd3;
	localparam logic [STATUS_W-1:0] ST_IGNORED = 3'd4;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_ROOT_INDEX = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_END_SYMBOL = 1'd1;

	localparam logic [SYM_W-1:0] END_SYMBOL_RESET = 9'd256;

	typedef struct packed {
		logic [OP_W-1:0]  op;
		logic [IDX_W-1:0] node_index;
		logic             node_is_leaf;
		logic [SYM_W-1:0] node_symbol;
		logic [IDX_W-1:0] zero_child;
		logic [IDX_W-1:0] one_child;
		logic             code_bit;
	} item_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [BYTE_W-1:0]   symbol;
	} result_t;

	// node table entry, same bit layout as the stored word
	typedef struct packed {
		logic             leaf;
		logic [SYM_W-1:0] symbol;
		logic [IDX_W-1:0] zero_child;
		logic [IDX_W-1:0] one_child;
	} entry_t;

	typedef enum logic [1:0] {
		K_ACK     = 2'd0,
		K_WRITE   = 2'd1,
		K_DECODE  = 2'd2,
		K_RESTART = 2'd3
	} kind_t;

	// classified request handed from front to back
	typedef struct packed {
		kind_t            kind;
		logic [IDX_W-1:0] node_index;
		entry_t           entry;
		logic             code_bit;
	} cmd_t;

	typedef struct packed {
		logic [IDX_W-1:0] root_index;
		logic [SYM_W-1:0] end_symbol;
		logic             root_moved;
	} cfg_t;

	function automatic logic in_range(input logic [IDX_W-1:0] idx);
		return 32'(idx) < 32'(NODE_COUNT);
	endfunction

endpackage

// ===== src/htd_ram.sv =====
// generic single write port, single read port ram with registered read data
// no dependencies
module htd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== src/htd_front.sv =====
// front end: takes requests, classifies them and queues them for the back end
// depends on htd_pkg
module htd_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           item_valid,
	output logic           item_ready,
	input  htd_pkg::item_t item,
	output logic           cmd_valid,
	input  logic           cmd_ready,
	output htd_pkg::cmd_t  cmd
);

	htd_pkg::cmd_t                    q_mem_q [htd_pkg::QUEUE_DEPTH];
	logic [htd_pkg::QPTR_W-1:0]       wr_ptr_q;
	logic [htd_pkg::QPTR_W-1:0]       rd_ptr_q;
	logic [htd_pkg::QCNT_W-1:0]       count_q;
	htd_pkg::cmd_t                    new_cmd;
	logic                             push;
	logic                             pop;

	always_comb begin
		new_cmd.node_index       = item.node_index;
		new_cmd.entry.leaf       = item.node_is_leaf;
		new_cmd.entry.symbol     = item.node_symbol;
		new_cmd.entry.zero_child = item.zero_child;
		new_cmd.entry.one_child  = item.one_child;
		new_cmd.code_bit         = item.code_bit;
		case (item.op)
			htd_pkg::OP_WRITE: begin
				// a write beyond the table only gets its answer
				new_cmd.kind = htd_pkg::in_range(item.node_index) ?
					htd_pkg::K_WRITE : htd_pkg::K_ACK;
			end
			htd_pkg::OP_DECODE:  new_cmd.kind = htd_pkg::K_DECODE;
			htd_pkg::OP_RESTART: new_cmd.kind = htd_pkg::K_RESTART;
			default:             new_cmd.kind = htd_pkg::K_ACK;
		endcase
	end

	assign item_ready = (count_q != htd_pkg::QCNT_W'(htd_pkg::QUEUE_DEPTH));
	assign cmd_valid  = (count_q != '0);
	assign cmd        = q_mem_q[rd_ptr_q];
	assign push       = item_valid && item_ready;
	assign pop        = cmd_valid && cmd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == htd_pkg::QPTR_W'(htd_pkg::QUEUE_DEPTH - 1)) ?
					'0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == htd_pkg::QPTR_W'(htd_pkg::QUEUE_DEPTH - 1)) ?
					'0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem_q[wr_ptr_q] <= new_cmd;
		end
	end

endmodule

// ===== src/htd_back.sv =====
// back end: node table, tree walk and result register
// depends on htd_pkg and htd_ram
module htd_back (
	input  logic             clk,
	input  logic             arst_n,
	input  htd_pkg::cfg_t    cfg,
	input  logic             cmd_valid,
	output logic             cmd_ready,
	input  htd_pkg::cmd_t    cmd,
	output logic             result_valid,
	input  logic             result_ready,
	output htd_pkg::result_t result
);

	typedef enum logic [2:0] {
		BE_RUN  = 3'b001,
		BE_WALK = 3'b010,
		BE_ROOT = 3'b100
	} be_state_t;

	be_state_t                    state_q, state_d;
	logic [htd_pkg::IDX_W-1:0]    cur_node_q, cur_node_d;
	logic                         done_q, done_d;
	logic                         stale_q, stale_d;
	logic                         out_valid_q, out_valid_d;
	htd_pkg::entry_t              cur_entry_q, cur_entry_d;
	htd_pkg::entry_t              root_entry_q, root_entry_d;
	logic [htd_pkg::IDX_W-1:0]    child_q, child_d;
	logic                         rd_ok_q, rd_ok_d;
	htd_pkg::result_t             out_q, out_d;

	logic                         ram_we;
	logic                         ram_re;
	logic [htd_pkg::ADDR_W-1:0]   ram_raddr;
	logic [htd_pkg::ENTRY_W-1:0]  ram_rdata;
	htd_pkg::entry_t              rd_entry;
	logic [htd_pkg::IDX_W-1:0]    child;
	logic                         out_free;

	htd_ram #(
		.WIDTH(htd_pkg::ENTRY_W),
		.DEPTH(htd_pkg::NODE_COUNT)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(htd_pkg::ADDR_W'(cmd.node_index)),
		.wdata(cmd.entry),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// an index beyond the table reads as an all-zero entry
	assign rd_entry = rd_ok_q ? htd_pkg::entry_t'(ram_rdata) : '0;
	assign child    = cmd.code_bit ? cur_entry_q.one_child : cur_entry_q.zero_child;
	assign out_free = !out_valid_q || result_ready;

	always_comb begin
		state_d      = state_q;
		cur_node_d   = cur_node_q;
		done_d       = done_q;
		stale_d      = stale_q;
		cur_entry_d  = cur_entry_q;
		root_entry_d = root_entry_q;
		child_d      = child_q;
		rd_ok_d      = rd_ok_q;
		out_d        = out_q;
		out_valid_d  = out_valid_q && !result_ready;
		cmd_ready    = 1'b0;
		ram_we       = 1'b0;
		ram_re       = 1'b0;
		ram_raddr    = '0;

		case (state_q)
			BE_RUN: begin
				if (stale_q) begin
					// refetch the root entry after the root moved
					ram_re    = 1'b1;
					ram_raddr = htd_pkg::ADDR_W'(cfg.root_index);
					rd_ok_d   = htd_pkg::in_range(cfg.root_index);
					state_d   = BE_ROOT;
				end else if (cmd_valid && out_free) begin
					cmd_ready    = 1'b1;
					out_d.status = htd_pkg::ST_NONE;
					out_d.symbol = '0;
					out_valid_d  = 1'b1;
					case (cmd.kind)
						htd_pkg::K_WRITE: begin
							ram_we = 1'b1;
							// keep the cached entries coherent with the table
							if (cmd.node_index == cur_node_q) begin
								cur_entry_d = cmd.entry;
							end
							if (cmd.node_index == cfg.root_index) begin
								root_entry_d = cmd.entry;
							end
						end
						htd_pkg::K_RESTART: begin
							cur_node_d  = cfg.root_index;
							cur_entry_d = root_entry_q;
							done_d      = 1'b0;
						end
						htd_pkg::K_DECODE: begin
							if (done_q) begin
								out_d.status = htd_pkg::ST_IGNORED;
							end else if (root_entry_q.leaf &&
								root_entry_q.symbol == cfg.end_symbol) begin
								out_d.status = htd_pkg::ST_EMPTY;
							end else begin
								out_valid_d = out_valid_q && !result_ready;
								ram_re      = 1'b1;
								ram_raddr   = htd_pkg::ADDR_W'(child);
								rd_ok_d     = htd_pkg::in_range(child);
								child_d     = child;
								state_d     = BE_WALK;
							end
						end
						default: begin
						end
					endcase
				end
			end
			BE_WALK: begin
				if (out_free) begin
					out_valid_d  = 1'b1;
					out_d.status = htd_pkg::ST_NONE;
					out_d.symbol = '0;
					state_d      = BE_RUN;
					if (rd_entry.leaf) begin
						cur_node_d  = cfg.root_index;
						cur_entry_d = root_entry_q;
						if (rd_entry.symbol == cfg.end_symbol) begin
							done_d       = 1'b1;
							out_d.status = htd_pkg::ST_END;
						end else begin
							out_d.status = htd_pkg::ST_SYMBOL;
							out_d.symbol = rd_entry.symbol[htd_pkg::BYTE_W-1:0];
						end
					end else begin
						cur_node_d  = child_q;
						cur_entry_d = rd_entry;
					end
				end
			end
			BE_ROOT: begin
				root_entry_d = rd_entry;
				stale_d      = 1'b0;
				state_d      = BE_RUN;
			end
			default: begin
				state_d = BE_RUN;
			end
		endcase

		if (cfg.root_moved) begin
			stale_d = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BE_RUN;
			cur_node_q  <= '0;
			done_q      <= 1'b0;
			stale_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			cur_node_q  <= cur_node_d;
			done_q      <= done_d;
			stale_q     <= stale_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		cur_entry_q  <= cur_entry_d;
		root_entry_q <= root_entry_d;
		child_q      <= child_d;
		rd_ok_q      <= rd_ok_d;
		out_q        <= out_d;
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

endmodule

// ===== src/huffman_tree_decoder.sv =====
// huffman tree decoder: one result per request, node table loaded by write requests
// requests pass the front queue, then the result register; a decode also waits for the
//   node memory read whose leaf test picks the next node; the back end takes no request
//   meanwhile, other requests go one per cycle while the result register is free
// a root_index write makes the back end refetch the root entry before the next request
// reset: walk at node 0, end flag cleared, root_index 0, end_symbol 256; table undefined
module huffman_tree_decoder (
	input  logic                              clk,
	input  logic                              arst_n,
	// request channel
	input  logic                              item_valid,
	output logic                              item_ready,
	input  htd_pkg::item_t                    item,
	// result channel
	output logic                              result_valid,
	input  logic                              result_ready,
	output htd_pkg::result_t                  result,
	// configuration write port
	input  logic                              cfg_we,
	input  logic [htd_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [htd_pkg::CFG_W-1:0]         cfg_data
);

	// configuration registers
	logic [htd_pkg::IDX_W-1:0] root_index_q;
	logic [htd_pkg::SYM_W-1:0] end_symbol_q;
	htd_pkg::cfg_t             cfg;

	// queue head between front and back
	logic                      cmd_valid;
	logic                      cmd_ready;
	htd_pkg::cmd_t             cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			root_index_q <= '0;
			end_symbol_q <= htd_pkg::END_SYMBOL_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				htd_pkg::CFG_ROOT_INDEX: root_index_q <= cfg_data[htd_pkg::IDX_W-1:0];
				htd_pkg::CFG_END_SYMBOL: end_symbol_q <= cfg_data[htd_pkg::SYM_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// the back end keeps a copy of the root entry; a new root index invalidates it
	assign cfg.root_index = root_index_q;
	assign cfg.end_symbol = end_symbol_q;
	assign cfg.root_moved = cfg_we && (cfg_index == htd_pkg::CFG_ROOT_INDEX);

	// front: classify each request and queue it
	htd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.item      (item),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd)
	);

	// back: node table, walk state and the result register
	htd_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.cmd_valid   (cmd_valid),
		.cmd_ready   (cmd_ready),
		.cmd         (cmd),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result      (result)
	);

`ifndef NO_ASSERTIONS
	// after a request is accepted, the queue presents a request in the next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready |=> cmd_valid)
		else $error("accepted request missing from queue");

	// the back end takes a request only when the result register can take its answer
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready |-> !result_valid || result_ready)
		else $error("request taken while result register is blocked");

	// after the root moves, no request is taken before the root entry is refetched
	assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we && cfg_index == htd_pkg::CFG_ROOT_INDEX |=> !(cmd_valid && cmd_ready))
		else $error("request taken with a stale root entry");
`endif

endmodule
